FILE: design/wrm_pkg.sv
// package for the weighted random multiset: field widths, codes,
// controller/datapath command and status structs; no dependencies
package wrm_pkg;

  localparam int DEFAULT_CAPACITY = 256;
  localparam int VALUE_W          = 32;
  localparam int RND_W            = 32;
  localparam int MODE_W           = 2;
  localparam int STATUS_W         = 2;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_WRITE_INS,
    ST_READ_LAST,
    ST_MOVE,
    ST_MOD,
    ST_READ_SAMP,
    ST_RESULT
  } state_e;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_FULL,
    RES_EMPTY,
    RES_INSERT,
    RES_REMOVE,
    RES_SAMPLE
  } res_sel_e;

  typedef struct packed {
    logic     load;
    logic     scan_start;
    logic     scan_step;
    logic     wr_ins;
    logic     rd_last;
    logic     wr_move;
    logic     mod_start;
    logic     mod_step;
    logic     rd_samp;
    logic     out_load;
    res_sel_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              empty;
    logic              scan_done;
    logic              mod_done;
    logic              found;
    logic              out_free;
  } sts_t;

endpackage

FILE: design/weighted_random_multiset.sv
// weighted random multiset, n = occupied slots: insert and remove scan all n slots,
// sample runs the remainder unit; refused requests and mode 3 skip to the result;
// the scan reads one slot per cycle and the sample remainder takes one bit of
// random_word per cycle; one request at a time
// the next request is taken in the cycle after the result is loaded, even while it waits
// async active-low reset empties the set; slot memory is not cleared and needs no pass
module weighted_random_multiset import wrm_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic        [MODE_W-1:0]   mode_i,
  input  logic signed [VALUE_W-1:0]  value_i,
  input  logic        [RND_W-1:0]    random_word_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       ok_o,
  output logic        [STATUS_W-1:0] status_o,
  output logic signed [VALUE_W-1:0]  sampled_value_o
);

  // command and status between the controller and the datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: decode, scan, move, remainder and result handoff
  wrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // slot memory, fill count, scan compare, remainder unit and result register
  wrm_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .mode_i          (mode_i),
    .value_i         (value_i),
    .random_word_i   (random_word_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .ok_o            (ok_o),
    .status_o        (status_o),
    .sampled_value_o (sampled_value_o)
  );

endmodule

FILE: design/wrm_ctrl.sv
// controller state machine for the weighted random multiset
// depends on wrm_pkg (state, command and status types)
module wrm_ctrl import wrm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e   state_q, state_d;
  res_sel_e res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      res_q   <= RES_ZERO;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    cmd_o       = '0;
    cmd_o.res_sel = res_q;
    in_stall_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts_i.mode)
          MODE_INSERT: begin
            if (sts_i.full) begin
              res_d   = RES_FULL;
              state_d = ST_RESULT;
            end else begin
              res_d            = RES_INSERT;
              cmd_o.scan_start = 1'b1;
              state_d          = ST_SCAN;
            end
          end
          MODE_REMOVE: begin
            res_d            = RES_REMOVE;
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end
          MODE_SAMPLE: begin
            if (sts_i.empty) begin
              res_d   = RES_EMPTY;
              state_d = ST_RESULT;
            end else begin
              res_d           = RES_SAMPLE;
              cmd_o.mod_start = 1'b1;
              state_d         = ST_MOD;
            end
          end
          default: begin
            res_d   = RES_ZERO;
            state_d = ST_RESULT;
          end
        endcase
      end
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          if (res_q == RES_INSERT) begin
            state_d = ST_WRITE_INS;
          end else if (sts_i.found) begin
            state_d = ST_READ_LAST;
          end else begin
            state_d = ST_RESULT;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ST_WRITE_INS: begin
        cmd_o.wr_ins = 1'b1;
        state_d      = ST_RESULT;
      end
      ST_READ_LAST: begin
        cmd_o.rd_last = 1'b1;
        state_d       = ST_MOVE;
      end
      ST_MOVE: begin
        cmd_o.wr_move = 1'b1;
        state_d       = ST_RESULT;
      end
      ST_MOD: begin
        if (sts_i.mod_done) begin
          state_d = ST_READ_SAMP;
        end else begin
          cmd_o.mod_step = 1'b1;
        end
      end
      ST_READ_SAMP: begin
        cmd_o.rd_samp = 1'b1;
        state_d       = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: design/wrm_dpath.sv
// datapath for the weighted random multiset: slot memory, scan unit,
// bit-serial remainder unit and result register; depends on wrm_pkg
module wrm_dpath import wrm_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  output sts_t                       sts_o,
  input  logic        [MODE_W-1:0]   mode_i,
  input  logic signed [VALUE_W-1:0]  value_i,
  input  logic        [RND_W-1:0]    random_word_i,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output logic                       ok_o,
  output logic        [STATUS_W-1:0] status_o,
  output logic signed [VALUE_W-1:0]  sampled_value_o
);

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int SLOT_W = IDX_W + VALUE_W;
  localparam int STEP_W = $clog2(RND_W + 1);

  // request fields
  logic [MODE_W-1:0]  mode_q;
  logic [VALUE_W-1:0] val_q;
  logic [RND_W-1:0]   rnd_q;

  // slot memory, {rank, value}
  logic [SLOT_W-1:0] mem_q [CAPACITY];
  logic [SLOT_W-1:0] rdata_q;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [SLOT_W-1:0] wr_data;

  logic [CNT_W-1:0] fill_q, fill_d;

  // scan
  logic [CNT_W-1:0] scan_q, scan_d;
  logic             rvalid_q, rvalid_d;
  logic [IDX_W-1:0] ridx_q, ridx_d;
  logic [IDX_W-1:0] copies_q, copies_d;
  logic [IDX_W-1:0] best_q, best_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic             found_q, found_d;
  logic             scan_issue;
  logic             hit;
  logic [IDX_W-1:0] rd_rank;

  // remainder
  logic [RND_W-1:0]  div_q, div_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W:0]    rem_shift;

  // result register
  logic                out_valid_q, out_valid_d;
  logic                ok_q, ok_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [VALUE_W-1:0]  sampled_q, sampled_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      val_q  <= value_i;
      rnd_q  <= random_word_i;
    end
  end

  assign scan_issue = cmd_i.scan_step && (scan_q != fill_q);
  assign rd_en      = scan_issue || cmd_i.rd_last || cmd_i.rd_samp;

  always_comb begin
    rd_addr = scan_q[IDX_W-1:0];
    if (cmd_i.rd_last) begin
      rd_addr = IDX_W'(fill_q - 1'b1);
    end else if (cmd_i.rd_samp) begin
      rd_addr = rem_q[IDX_W-1:0];
    end
  end

  assign wr_en   = cmd_i.wr_ins || cmd_i.wr_move;
  assign wr_addr = cmd_i.wr_ins ? IDX_W'(fill_q) : pos_q;
  assign wr_data = cmd_i.wr_ins ? {copies_q, val_q} : rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.wr_ins) begin
      fill_d = fill_q + 1'b1;
    end else if (cmd_i.wr_move) begin
      fill_d = fill_q - 1'b1;
    end
  end

  // compare stage of the scan, one slot a cycle
  assign rd_rank = rdata_q[SLOT_W-1:VALUE_W];
  assign hit     = rvalid_q && (rdata_q[VALUE_W-1:0] == val_q);

  always_comb begin
    scan_d   = scan_q;
    rvalid_d = 1'b0;
    ridx_d   = ridx_q;
    copies_d = copies_q;
    best_d   = best_q;
    pos_d    = pos_q;
    found_d  = found_q;
    if (cmd_i.scan_start) begin
      scan_d   = '0;
      copies_d = '0;
      best_d   = '0;
      pos_d    = '0;
      found_d  = 1'b0;
    end else begin
      if (scan_issue) begin
        scan_d   = scan_q + 1'b1;
        rvalid_d = 1'b1;
        ridx_d   = scan_q[IDX_W-1:0];
      end
      if (hit) begin
        copies_d = copies_q + 1'b1;
        if (!found_q || (rd_rank > best_q)) begin
          found_d = 1'b1;
          best_d  = rd_rank;
          pos_d   = ridx_q;
        end
      end
    end
  end

  // restoring remainder, one dividend bit a cycle
  assign rem_shift = {rem_q, div_q[RND_W-1]};

  always_comb begin
    div_d  = div_q;
    rem_d  = rem_q;
    step_d = step_q;
    if (cmd_i.mod_start) begin
      div_d  = rnd_q;
      rem_d  = '0;
      step_d = '0;
    end else if (cmd_i.mod_step) begin
      div_d  = {div_q[RND_W-2:0], 1'b0};
      step_d = step_q + 1'b1;
      if (rem_shift >= {1'b0, fill_q}) begin
        rem_d = CNT_W'(rem_shift - {1'b0, fill_q});
      end else begin
        rem_d = CNT_W'(rem_shift);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      scan_q   <= '0;
      rvalid_q <= 1'b0;
      found_q  <= 1'b0;
      step_q   <= '0;
    end else begin
      fill_q   <= fill_d;
      scan_q   <= scan_d;
      rvalid_q <= rvalid_d;
      found_q  <= found_d;
      step_q   <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q   <= ridx_d;
    copies_q <= copies_d;
    best_q   <= best_d;
    pos_q    <= pos_d;
    div_q    <= div_d;
    rem_q    <= rem_d;
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    ok_d        = ok_q;
    status_d    = status_q;
    sampled_d   = sampled_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      ok_d        = 1'b0;
      status_d    = STATUS_DONE;
      sampled_d   = '0;
      unique case (cmd_i.res_sel)
        RES_ZERO:   ok_d = 1'b0;
        RES_FULL:   status_d = STATUS_FULL;
        RES_EMPTY:  status_d = STATUS_EMPTY;
        RES_INSERT: ok_d = (copies_q == '0);
        RES_REMOVE: ok_d = found_q;
        RES_SAMPLE: begin
          ok_d      = 1'b1;
          sampled_d = rdata_q[VALUE_W-1:0];
        end
        default:    ok_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q      <= ok_d;
    status_q  <= status_d;
    sampled_q <= sampled_d;
  end

  assign out_valid_o     = out_valid_q;
  assign ok_o            = ok_q;
  assign status_o        = status_q;
  assign sampled_value_o = sampled_q;

  assign sts_o.mode      = mode_q;
  assign sts_o.full      = (fill_q == CNT_W'(CAPACITY));
  assign sts_o.empty     = (fill_q == '0);
  assign sts_o.scan_done = (scan_q == fill_q) && !rvalid_q;
  assign sts_o.mod_done  = (step_q == STEP_W'(RND_W));
  assign sts_o.found     = found_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

endmodule
